### design/pfsw_pkg.sv
package pfsw_pkg;

   localparam int STORE_BYTES    = 640;
   localparam int PANEL_WIDTH    = 96;
   localparam int PANEL_HEIGHT   = 16;
   localparam int HALF_WIDTH     = PANEL_WIDTH / 2;
   localparam int HEADER_BYTES   = 7;
   localparam int TRANSFER_BYTES = HEADER_BYTES + STORE_BYTES;
   localparam int ADDR_W         = $clog2(STORE_BYTES);
   localparam int POS_W          = $clog2(TRANSFER_BYTES);
   localparam int HDR_IDX_W      = $clog2(HEADER_BYTES);

   // Layout of the folded rows
   localparam int TOP_LEFT_BASE  = 112;
   localparam int TOP_RIGHT_BASE = 16;
   localparam int BOTTOM_BASE    = 48;

   // Panel command bytes
   localparam logic [7:0] OP_COLUMN_SET = 8'h2A;
   localparam logic [7:0] OP_ROW_SET    = 8'h2B;
   localparam logic [7:0] OP_MEM_WRITE  = 8'h2C;
   localparam logic [7:0] LAST_COLUMN   = 8'd159;
   localparam logic [7:0] LAST_ROW      = 8'd3;

   typedef enum logic [1:0] {
      CMD_SET_PIXEL = 2'd0,
      CMD_CLEAR     = 2'd1,
      CMD_SEND      = 2'd2
   } cmd_type;

   // Controller to datapath
   typedef struct packed {
      logic read_pix;
      logic read_send;
      logic write_pix;
      logic write_clear;
      logic load_out;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pix_ok;
      logic clear_last;
      logic out_free;
   } dpath_status_type;

   // Header byte with its register-select flag: {rs, data}
   function automatic logic [8:0] header_entry(input logic [HDR_IDX_W-1:0] idx);
      logic [8:0] entry;
      case (idx)
         3'd0:    entry = {1'b0, OP_COLUMN_SET};
         3'd1:    entry = {1'b1, 8'd0};
         3'd2:    entry = {1'b1, LAST_COLUMN};
         3'd3:    entry = {1'b0, OP_ROW_SET};
         3'd4:    entry = {1'b1, 8'd0};
         3'd5:    entry = {1'b1, LAST_ROW};
         3'd6:    entry = {1'b0, OP_MEM_WRITE};
         default: entry = {1'b1, 8'd0};
      endcase
      return entry;
   endfunction

endpackage

### design/pfsw_if.sv
interface pfsw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [6:0] x;
   logic [4:0] y;
   logic [3:0] color;

   modport source (output valid, output cmd, output x, output y, output color, input ready);
   modport sink   (input valid, input cmd, input x, input y, input color, output ready);
endinterface

interface pfsw_rsp_if;
   logic       valid;
   logic       ready;
   logic       rs;
   logic [7:0] data;
   logic       last;

   modport source (output valid, output rs, output data, output last, input ready);
   modport sink   (input valid, input rs, input data, input last, output ready);
endinterface

### design/pfsw_ctrl.sv
module pfsw_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [1:0]                  req_cmd,
   output logic                        req_ready,
   input  pfsw_pkg::dpath_status_type  status,
   output pfsw_pkg::ctrl_cmd_type      ctrl
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_WRITE,
      ST_SEND_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.write_clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (pfsw_pkg::cmd_type'(req_cmd))
                  pfsw_pkg::CMD_SET_PIXEL: begin
                     if (status.pix_ok) begin
                        ctrl.read_pix = 1'b1;
                        state_in      = ST_PIX_WRITE;
                     end
                  end
                  pfsw_pkg::CMD_CLEAR: state_in = ST_CLEAR;
                  pfsw_pkg::CMD_SEND: begin
                     ctrl.read_send = 1'b1;
                     state_in       = ST_SEND_OUT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PIX_WRITE: begin
            ctrl.write_pix = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SEND_OUT: begin
            // hold the fetched byte until the output register frees up
            if (status.out_free) begin
               ctrl.load_out = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/pfsw_dpath.sv
module pfsw_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [6:0]                  req_x,
   input  logic [4:0]                  req_y,
   input  logic [3:0]                  req_color,
   input  pfsw_pkg::ctrl_cmd_type      ctrl,
   output pfsw_pkg::dpath_status_type  status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_rs,
   output logic [7:0]                  rsp_data,
   output logic                        rsp_last
);

   localparam int AW = pfsw_pkg::ADDR_W;
   localparam int PW = pfsw_pkg::POS_W;

   logic [7:0]    store_mem [pfsw_pkg::STORE_BYTES];
   logic [7:0]    rd_ff;
   logic [AW-1:0] wr_addr_ff;
   logic          low_nib_ff;
   logic [3:0]    color_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] clr_in;
   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          rs_ff;
   logic [7:0]    data_ff;
   logic          last_ff;

   logic [2:0]    row;
   logic [1:0]    band;
   logic [AW-1:0] band_base;
   logic [AW-1:0] col_off;
   logic [AW-1:0] pix_addr;
   logic          left_half;
   logic          in_panel;
   logic          low_nib;
   logic          is_header;
   logic          pos_final;
   logic [AW-1:0] send_addr;
   logic [AW-1:0] rd_addr;
   logic [7:0]    merged;
   logic [8:0]    hdr;

   // fold the row into a band, four bands per half
   assign row       = req_y[2:0];
   assign band      = row[2] ? row[1:0] : ~row[1:0];
   assign band_base = {1'b0, band, 7'b0} + {3'b0, band, 5'b0};
   assign left_half = req_x < 7'(pfsw_pkg::HALF_WIDTH);
   assign in_panel  = (req_x < 7'(pfsw_pkg::PANEL_WIDTH)) && (req_y < 5'(pfsw_pkg::PANEL_HEIGHT));

   always_comb begin
      if (req_y[3]) begin
         // bottom half: mirrored column
         col_off = AW'(pfsw_pkg::BOTTOM_BASE + pfsw_pkg::PANEL_WIDTH - 1) - {3'b0, req_x};
      end else if (left_half) begin
         col_off = AW'(pfsw_pkg::TOP_LEFT_BASE) + {3'b0, req_x};
      end else begin
         col_off = {3'b0, req_x} - AW'(pfsw_pkg::HALF_WIDTH - pfsw_pkg::TOP_RIGHT_BASE);
      end
   end

   assign pix_addr = band_base + col_off;
   assign low_nib  = left_half ? !row[2] : row[2];

   assign is_header = pos_ff < PW'(pfsw_pkg::HEADER_BYTES);
   assign pos_final = pos_ff == PW'(pfsw_pkg::TRANSFER_BYTES - 1);
   assign send_addr = is_header ? '0 : AW'(pos_ff - PW'(pfsw_pkg::HEADER_BYTES));
   assign rd_addr   = ctrl.read_pix ? pix_addr : send_addr;
   assign merged    = low_nib_ff ? {rd_ff[7:4], color_ff} : {color_ff, rd_ff[3:0]};
   assign hdr       = pfsw_pkg::header_entry(pos_ff[pfsw_pkg::HDR_IDX_W-1:0]);

   assign status.pix_ok     = in_panel && (pix_addr < AW'(pfsw_pkg::STORE_BYTES));
   assign status.clear_last = clr_ff == AW'(pfsw_pkg::STORE_BYTES - 1);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (ctrl.write_clear) begin
         store_mem[clr_ff] <= 8'd0;
      end else if (ctrl.write_pix) begin
         store_mem[wr_addr_ff] <= merged;
      end
      if (ctrl.read_pix || ctrl.read_send) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.read_pix) begin
         wr_addr_ff <= pix_addr;
         low_nib_ff <= low_nib;
         color_ff   <= req_color;
      end
      if (ctrl.load_out) begin
         if (is_header) begin
            rs_ff   <= hdr[8];
            data_ff <= hdr[7:0];
            last_ff <= 1'b0;
         end else begin
            rs_ff   <= 1'b1;
            data_ff <= rd_ff;
            last_ff <= pos_final;
         end
      end
   end

   always_comb begin
      clr_in = clr_ff;
      if (ctrl.write_clear) begin
         clr_in = status.clear_last ? '0 : clr_ff + AW'(1);
      end
      pos_in = pos_ff;
      if (ctrl.load_out) begin
         pos_in = pos_final ? '0 : pos_ff + PW'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rs    = rs_ff;
   assign rsp_data  = data_ff;
   assign rsp_last  = last_ff;

endmodule

### design/panel_frame_store_writer.sv
// Send: the byte is read from the store on acceptance, then loaded into the rsp output
// register once that register is free. Req ready stays low until a transaction is done:
// set pixel reads, then writes the one store port; clear zeroes one store byte per cycle;
// off-panel or unused requests finish on acceptance.
// Reset: synchronous; afterwards a clearing pass over the whole store runs with req ready low,
// the transfer position returns to the first header byte and rsp is empty.
module panel_frame_store_writer (
   input  logic          clock,
   input  logic          reset,
   pfsw_req_if.sink      req_chan,
   pfsw_rsp_if.source    rsp_chan
);

   pfsw_pkg::ctrl_cmd_type     ctrl;
   pfsw_pkg::dpath_status_type status;

   // Controller: sequence each transaction through the single store port
   pfsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // Datapath: map pixels to bytes, hold the store, walk the transfer
   pfsw_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_x     (req_chan.x),
      .req_y     (req_chan.y),
      .req_color (req_chan.color),
      .ctrl      (ctrl),
      .status    (status),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_rs    (rsp_chan.rs),
      .rsp_data  (rsp_chan.data),
      .rsp_last  (rsp_chan.last)
   );

   // A clear must block new transactions while the sweep runs
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.cmd == pfsw_pkg::CMD_CLEAR)
      |=> !req_chan.ready)
      else $error("request accepted right after clear");

   // An on-panel pixel write finishes its read-modify-write in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.cmd == pfsw_pkg::CMD_SET_PIXEL
       && status.pix_ok) |=> ctrl.write_pix)
      else $error("pixel write missing after read");

   // Never drop a waiting result
   assert property (@(posedge clock) disable iff (reset)
      ctrl.load_out |-> status.out_free)
      else $error("output register overwritten");

   // Sweep and pixel write never contend for the store port
   assert property (@(posedge clock) disable iff (reset)
      !(ctrl.write_pix && ctrl.write_clear))
      else $error("store write conflict");

endmodule

### sim/tb_top.sv
module tb_top;

   // Command code that the block has no operation for
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int AW            = pfsw_pkg::ADDR_W;
   localparam int BAND_STRIDE   = 160;
   localparam int MAX_WAIT      = 16;
   localparam int RANDOM_OPS    = 1200;
   localparam int DRAIN_EVERY   = 300;
   localparam int SETTLE_CYCLES = 50;

   typedef struct packed {
      logic       wait_idle;   // marker: hold the sender until nothing is outstanding
      logic [1:0] cmd;
      logic [6:0] x;
      logic [4:0] y;
      logic [3:0] color;
   } panel_op_type;

   typedef struct packed {
      logic       rs;
      logic [7:0] data;
      logic       last;
   } panel_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfsw_req_if req_bus ();
   pfsw_rsp_if rsp_bus ();

   panel_frame_store_writer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Stimulus waiting for the driver, and panel bytes waiting for the monitor
   panel_op_type   ops_pending[$];
   panel_byte_type bytes_due[$];

   // Shadow copy of the frame store and of the transfer position
   logic [7:0]  store_shadow [pfsw_pkg::STORE_BYTES] = '{default: 8'h00};
   int          send_pos = 0;

   // Handshake flags captured at the rising edge, used by the falling-edge drivers
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;

   int req_gap    = 0;
   int rsp_stall  = 0;
   bit req_burst  = 1'b0;
   bit rsp_burst  = 1'b0;
   bit stimulus_done = 1'b0;

   int errors        = 0;
   int ops_accepted  = 0;
   int bytes_checked = 0;
   int frames_sent   = 0;
   int pixels_set    = 0;
   int pixels_off    = 0;
   int clears_done   = 0;
   int ops_ignored   = 0;

   always #2 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Run the accepted transaction through the shadow frame store; a send
   // transaction queues the panel byte that must come out for it.
   task automatic predict_op(input logic [1:0] cmd, input logic [6:0] x,
                             input logic [4:0] y, input logic [3:0] color);
      int             row;
      int             band;
      int             addr;
      bit             top;
      bit             left;
      bit             low_nib;
      panel_byte_type b;
      case (cmd)
         pfsw_pkg::CMD_SET_PIXEL: begin
            if (x >= pfsw_pkg::PANEL_WIDTH || y >= pfsw_pkg::PANEL_HEIGHT) begin
               pixels_off++;
            end else begin
               top  = (y < pfsw_pkg::PANEL_HEIGHT / 2);
               left = (x < pfsw_pkg::HALF_WIDTH);
               row  = top ? int'(y) : int'(y) - pfsw_pkg::PANEL_HEIGHT / 2;
               // Rows fold outward from the middle of each half
               band = (row < 4) ? 3 - row : row - 4;
               if (top && left)
                  addr = pfsw_pkg::TOP_LEFT_BASE + BAND_STRIDE * band + int'(x);
               else if (top)
                  addr = pfsw_pkg::TOP_RIGHT_BASE + BAND_STRIDE * band
                         + (int'(x) - pfsw_pkg::HALF_WIDTH);
               else
                  addr = pfsw_pkg::BOTTOM_BASE + BAND_STRIDE * band
                         + (pfsw_pkg::PANEL_WIDTH - 1 - int'(x));
               // Right half swaps which nibble a row lands in
               low_nib = left ? (row < 4) : (row >= 4);
               if (addr < pfsw_pkg::STORE_BYTES) begin
                  if (low_nib)
                     store_shadow[AW'(addr)][3:0] = color;
                  else
                     store_shadow[AW'(addr)][7:4] = color;
               end
               pixels_set++;
            end
         end
         pfsw_pkg::CMD_CLEAR: begin
            // Zero the store; the transfer position stays where it is
            foreach (store_shadow[i]) store_shadow[i] = 8'h00;
            clears_done++;
         end
         pfsw_pkg::CMD_SEND: begin
            b.last = 1'b0;
            b.rs   = 1'b1;
            case (send_pos)
               0: begin b.rs = 1'b0; b.data = pfsw_pkg::OP_COLUMN_SET; end
               1: b.data = 8'd0;
               2: b.data = pfsw_pkg::LAST_COLUMN;
               3: begin b.rs = 1'b0; b.data = pfsw_pkg::OP_ROW_SET; end
               4: b.data = 8'd0;
               5: b.data = pfsw_pkg::LAST_ROW;
               6: begin b.rs = 1'b0; b.data = pfsw_pkg::OP_MEM_WRITE; end
               default: begin
                  b.data = store_shadow[AW'(send_pos - pfsw_pkg::HEADER_BYTES)];
                  b.last = (send_pos == pfsw_pkg::TRANSFER_BYTES - 1);
               end
            endcase
            bytes_due.push_back(b);
            send_pos = (send_pos == pfsw_pkg::TRANSFER_BYTES - 1) ? 0 : send_pos + 1;
         end
         default: ops_ignored++;
      endcase
   endtask

   function automatic void queue_op(input logic [1:0] cmd, input logic [6:0] x,
                                    input logic [4:0] y, input logic [3:0] color);
      panel_op_type op;
      op.wait_idle = 1'b0;
      op.cmd       = cmd;
      op.x         = x;
      op.y         = y;
      op.color     = color;
      ops_pending.push_back(op);
   endfunction

   // Stimulus: a directed opening, then a long random mix dominated by sends
   // so that at least one whole frame transfer goes out with pixel data in it.
   initial begin
      panel_op_type drain;
      int           pick;
      logic [6:0]   rx;
      logic [4:0]   ry;

      drain = '0;
      drain.wait_idle = 1'b1;

      // Panel corners and the seams between the quadrants
      queue_op(pfsw_pkg::CMD_SET_PIXEL, 7'd0,  5'd0,  4'hF);
      queue_op(pfsw_pkg::CMD_SET_PIXEL, 7'd47, 5'd7,  4'hA);
      queue_op(pfsw_pkg::CMD_SET_PIXEL, 7'd48, 5'd0,  4'h5);
      queue_op(pfsw_pkg::CMD_SET_PIXEL, 7'd95, 5'd15, 4'hC);
      queue_op(pfsw_pkg::CMD_SET_PIXEL, 7'd0,  5'd8,  4'h3);
      // Off-panel coordinates and the unused command must leave no trace
      queue_op(pfsw_pkg::CMD_SET_PIXEL, 7'd96,  5'd0,  4'h7);
      queue_op(pfsw_pkg::CMD_SET_PIXEL, 7'd0,   5'd16, 4'h7);
      queue_op(pfsw_pkg::CMD_SET_PIXEL, 7'd127, 5'd31, 4'hF);
      queue_op(CMD_UNUSED,              7'd127, 5'd31, 4'hF);
      // Overwrite one nibble, keep its neighbor
      queue_op(pfsw_pkg::CMD_SET_PIXEL, 7'd0, 5'd0, 4'h1);
      // Whole header plus the first store byte
      repeat (8) queue_op(pfsw_pkg::CMD_SEND, 7'd0, 5'd0, 4'h0);
      // Clear in the middle of a transfer keeps the position
      queue_op(pfsw_pkg::CMD_CLEAR, 7'd0, 5'd0, 4'h0);
      repeat (2) queue_op(pfsw_pkg::CMD_SEND, 7'd127, 5'd31, 4'hF);
      ops_pending.push_back(drain);

      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1) ops_pending.push_back(drain);
         pick = $urandom_range(0, 99);
         rx   = 7'($urandom_range(0, 127));
         ry   = 5'($urandom_range(0, 31));
         if (pick < 60) begin
            queue_op(pfsw_pkg::CMD_SEND, rx, ry, 4'($urandom_range(0, 15)));
         end else if (pick < 92) begin
            // Mostly on-panel pixels, now and then anywhere in the field range
            if ($urandom_range(0, 9) != 0) begin
               rx = 7'($urandom_range(0, pfsw_pkg::PANEL_WIDTH - 1));
               ry = 5'($urandom_range(0, pfsw_pkg::PANEL_HEIGHT - 1));
            end
            queue_op(pfsw_pkg::CMD_SET_PIXEL, rx, ry, 4'($urandom_range(0, 15)));
         end else if (pick < 98) begin
            queue_op(CMD_UNUSED, rx, ry, 4'($urandom_range(0, 15)));
         end else begin
            queue_op(pfsw_pkg::CMD_CLEAR, rx, ry, 4'($urandom_range(0, 15)));
         end
      end
   end

   // Sender: change on the falling edge, advance only after a transaction
   always @(negedge clock) begin
      panel_op_type op;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_took) begin
         if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (ops_pending.size() == 0) begin
            req_bus.valid <= 1'b0;
            stimulus_done <= 1'b1;
         end else if (ops_pending[0].wait_idle) begin
            // Hold until every queued panel byte has come out
            req_bus.valid <= 1'b0;
            if (bytes_due.size() == 0) void'(ops_pending.pop_front());
         end else begin
            op = ops_pending.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.cmd   <= op.cmd;
            req_bus.x     <= op.x;
            req_bus.y     <= op.y;
            req_bus.color <= op.color;
            // Switch between back-to-back stretches and random gaps
            if ($urandom_range(0, 63) == 0) req_burst <= ~req_burst;
            req_gap <= req_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end
      end
   end

   // Receiver: stall a random number of cycles after each transaction
   always @(negedge clock) begin
      int stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_took) begin
         if ($urandom_range(0, 63) == 0) rsp_burst <= ~rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
         rsp_bus.ready <= (stall == 0);
         rsp_stall <= stall;
      end else if (rsp_stall > 0) begin
         rsp_bus.ready <= (rsp_stall == 1);
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Monitor: sample both channels on the rising edge
   always @(posedge clock) begin
      panel_byte_type want;
      req_took <= !reset && req_bus.valid && req_bus.ready;
      rsp_took <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (bytes_due.size() == 0) begin
               $display("%0t: unexpected rsp transaction: expected none,",
                        $time, " got rs=%0b data=%02h last=%0b",
                        rsp_bus.rs, rsp_bus.data, rsp_bus.last);
               errors++;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_bus.rs !== want.rs) begin
                  $display("%0t: rs mismatch: expected %0b, got %0b", $time, want.rs, rsp_bus.rs);
                  errors++;
               end
               if (rsp_bus.data !== want.data) begin
                  $display("%0t: data mismatch: expected %02h, got %02h",
                           $time, want.data, rsp_bus.data);
                  errors++;
               end
               if (rsp_bus.last !== want.last) begin
                  $display("%0t: last mismatch: expected %0b, got %0b",
                           $time, want.last, rsp_bus.last);
                  errors++;
               end
               if (want.last) frames_sent++;
               bytes_checked++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_op(req_bus.cmd, req_bus.x, req_bus.y, req_bus.color);
            ops_accepted++;
         end
      end
   end

   // Wrap up once the stimulus is gone and every byte has been checked
   initial begin
      while (!stimulus_done) @(posedge clock);
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d req transactions: %0d pixel writes, %0d off-panel,",
               ops_accepted, pixels_set, pixels_off,
               " %0d clears, %0d ignored.", clears_done, ops_ignored);
      $display("Checked %0d panel bytes across %0d complete frame transfers, %0d mismatches.",
               bytes_checked, frames_sent, errors);
      if (errors == 0) begin
         $display("PASS panel_frame_store_writer");
      end else begin
         $display("FAIL panel_frame_store_writer");
      end
      $finish;
   end

   // Watchdog against a hung handshake
   initial begin
      #2000000;
      $display("Timeout with %0d panel bytes still outstanding.", bytes_due.size());
      $display("FAIL panel_frame_store_writer");
      $finish;
   end

endmodule
